### hw/rtl/key_press_classifier_unit_macros.svh
// Assertion macros used by the checker of the key press classifier.
`ifndef KEY_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define KPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key press classifier assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define KPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key press classifier assertion failed");

`endif

### hw/rtl/kpc_pkg.sv
// Package of the key press classifier: sizes, reset values, register indexes and types.
`timescale 1ns / 1ps
package kpc_pkg;

  localparam int unsigned NUM_KEYS  = 4;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 8'd70;
  localparam logic [CNT_W-1:0] DBL_WINDOW_RESET = 8'd35;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DBL_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DEB  = 2'd1,
    PH_HELD = 2'd2
  } kpc_phase_e;

  typedef struct packed {
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] double_click_window;
  } kpc_cfg_t;

  typedef struct packed {
    logic sgl;
    logic dbl;
    logic lng;
  } kpc_evt_t;

endpackage

### hw/rtl/kpc_key_unit.sv
// Per-key debounce, hold counting and click-window state machine.
`timescale 1ns / 1ps
module kpc_key_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              released_i,
  input  kpc_pkg::kpc_cfg_t cfg_i,
  output kpc_pkg::kpc_evt_t evt_o
);

  kpc_pkg::kpc_phase_e          phase_q, phase_d;
  logic [kpc_pkg::CNT_W-1:0]    hold_q, hold_d;
  logic                         win_q, win_d;
  logic [kpc_pkg::CNT_W-1:0]    wcnt_q, wcnt_d;

  always_comb begin
    logic                      win_mid;
    logic [kpc_pkg::CNT_W-1:0] wcnt_mid;
    phase_d  = phase_q;
    hold_d   = hold_q;
    win_mid  = win_q;
    wcnt_mid = wcnt_q;
    evt_o    = '0;

    case (phase_q)
      kpc_pkg::PH_DEB: begin
        phase_d = released_i ? kpc_pkg::PH_IDLE : kpc_pkg::PH_HELD;
      end
      kpc_pkg::PH_HELD: begin
        if (released_i) begin
          // A release past the long threshold ends silently.
          if (hold_q < cfg_i.long_press_ticks) begin
            if (!win_q) begin
              win_mid  = 1'b1;
              wcnt_mid = '0;
            end else begin
              evt_o.dbl = 1'b1;
              win_mid   = 1'b0;
            end
          end
          phase_d = kpc_pkg::PH_IDLE;
        end else if (hold_q >= cfg_i.long_press_ticks) begin
          evt_o.lng = 1'b1;
        end else begin
          hold_d = kpc_pkg::CNT_W'(hold_q + 1'b1);
        end
      end
      default: begin
        phase_d = kpc_pkg::PH_IDLE;
        if (!released_i) begin
          phase_d = kpc_pkg::PH_DEB;
          hold_d  = '0;
        end
      end
    endcase

    // The window is counted on the same tick that opens it.
    win_d  = win_mid;
    wcnt_d = wcnt_mid;
    if (win_mid) begin
      wcnt_d = kpc_pkg::CNT_W'(wcnt_mid + 1'b1);
      if (wcnt_d >= cfg_i.double_click_window) begin
        evt_o.sgl = 1'b1;
        win_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kpc_pkg::PH_IDLE;
      hold_q  <= '0;
      win_q   <= 1'b0;
      wcnt_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      win_q   <= win_d;
      wcnt_q  <= wcnt_d;
    end
  end

endmodule

### hw/rtl/key_press_classifier_unit.sv
// Top level of the key press classifier: input register, key units, result register.
`timescale 1ns / 1ps
// Usage:
// Each transfer on the s_axis channel is one scan tick; s_axis_tdata[3:0] holds the
// raw key levels, bit k low meaning key k is pressed. Every tick produces exactly one
// transfer on the m_axis channel carrying the single, double and long event masks.
// A tick passes the input register and then the result register before its result
// shows on m_axis, and it waits in the input register while m_axis is stalled.
// Throughput is one tick per cycle while m_axis_tready is high: the input register
// feeds four key units whose update is a single compare and increment each, and the
// result register parts the output side from the input side.
// When m_axis_tready is low the result holds; one more tick may wait in the input
// register, after which s_axis_tready drops until the result is taken.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) sets the long-press
// threshold (index 0) and the double-click window (index 1); write it only while
// no tick is in flight.
// Reset clears all key state, the registers go to 70 and 35 ticks, and both
// channels come up empty.
module key_press_classifier_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // key_levels[3:0], zeros [7:4]
  input  logic [kpc_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // single_mask[3:0], double_mask[7:4], long_mask[11:8], zeros [15:12]
  output logic [kpc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  input  logic                                   cfg_we_i,
  input  logic [kpc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [kpc_pkg::CFG_W-1:0]              cfg_data_i
);

  kpc_pkg::kpc_cfg_t                cfg_q;
  logic                             in_valid_q;
  logic [kpc_pkg::KEY_W-1:0]        levels_q;
  logic                             out_valid_q;
  logic [kpc_pkg::KEY_W-1:0]        sgl_q, sgl_d;
  logic [kpc_pkg::KEY_W-1:0]        dbl_q, dbl_d;
  logic [kpc_pkg::KEY_W-1:0]        lng_q, lng_d;
  logic                             advance;
  kpc_pkg::kpc_evt_t                evt [kpc_pkg::KEY_W];

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks    <= kpc_pkg::LONG_PRESS_RESET;
      cfg_q.double_click_window <= kpc_pkg::DBL_WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kpc_pkg::REG_LONG_PRESS: cfg_q.long_press_ticks    <= cfg_data_i;
        kpc_pkg::REG_DBL_WINDOW: cfg_q.double_click_window <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      levels_q <= s_axis_tdata[kpc_pkg::KEY_W-1:0];
    end
  end

  for (genvar k = 0; k < kpc_pkg::KEY_W; k++) begin : g_key
    if (k < kpc_pkg::NUM_KEYS) begin : g_used
      kpc_key_unit u_key (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .en_i       (advance),
        .released_i (levels_q[k]),
        .cfg_i      (cfg_q),
        .evt_o      (evt[k])
      );
    end else begin : g_unused
      assign evt[k] = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < kpc_pkg::KEY_W; k++) begin
      sgl_d[k] = evt[k].sgl;
      dbl_d[k] = evt[k].dbl;
      lng_d[k] = evt[k].lng;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sgl_q <= sgl_d;
      dbl_q <= dbl_d;
      lng_q <= lng_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, lng_q, dbl_q, sgl_q};

endmodule

### hw/rtl/kpc_checker.sv
// Port-level checker of the key press classifier and its bind to the top level.
`timescale 1ns / 1ps
`include "key_press_classifier_unit_macros.svh"
module kpc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [kpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result keeps its value until it is transferred.
  `KPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // The input side only stalls when a finished result is waiting.
  `KPC_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // A double click closes the window, so the same key never also reports a single click.
  `KPC_ASSERT_IMPL(a_single_double_apart, m_axis_tvalid, (m_axis_tdata[3:0] & m_axis_tdata[7:4]) == 4'b0000)

  // A double click needs a release, a long press needs the key held.
  `KPC_ASSERT_IMPL(a_double_long_apart, m_axis_tvalid, (m_axis_tdata[7:4] & m_axis_tdata[11:8]) == 4'b0000)

endmodule

bind key_press_classifier_unit kpc_checker u_kpc_checker (.*);

### verif/tb.sv
// Self-checking testbench for the key press classifier: directed ticks, then per-key press patterns.
`timescale 1ns / 1ps
module tb;
  import kpc_pkg::*;

  // Event masks of one tick, packed the way m_axis_tdata carries them.
  typedef struct packed {
    logic [3:0] lng_mask;
    logic [3:0] dbl_mask;
    logic [3:0] sgl_mask;
  } tick_events_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [3:0]   levels;
    logic [7:0]   thr;
    logic [7:0]   win;
    logic         chk;
    tick_events_t want;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] thr;
    logic [7:0] win;
    int         items;
    logic       idle;
  } phase_t;

  localparam int DIR_ROWS = 28;
  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{ROW_TICK, 4'hF, 8'd0,   8'd0,   1'b1, 12'h000},  // all keys up after reset
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'hF, 8'd0,   8'd0,   1'b1, 12'h000},  // one-tick bounce is dropped
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'hF, 8'd0,   8'd0,   1'b1, 12'h000},  // short click opens the window
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'hF, 8'd0,   8'd0,   1'b1, 12'h0F0},  // second click inside the window
    '{ROW_CFG,  4'hF, 8'd1,   8'd0,   1'b0, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},  // hold count reaches the threshold
    '{ROW_TICK, 4'hE, 8'd0,   8'd0,   1'b1, 12'h100},  // key 0 long, others release silently
    '{ROW_TICK, 4'hF, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'hF, 8'd0,   8'd0,   1'b1, 12'h00F},  // zero window fires on opening tick
    '{ROW_CFG,  4'hF, 8'd0,   8'd0,   1'b0, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_TICK, 4'h0, 8'd0,   8'd0,   1'b1, 12'hF00},  // zero threshold: every held tick long
    '{ROW_TICK, 4'hF, 8'd0,   8'd0,   1'b1, 12'h000},
    '{ROW_CFG,  4'hF, 8'd255, 8'd255, 1'b0, 12'h000},
    '{ROW_TICK, 4'h5, 8'd0,   8'd0,   1'b0, 12'h000},
    '{ROW_TICK, 4'hA, 8'd0,   8'd0,   1'b0, 12'h000},
    '{ROW_TICK, 4'h3, 8'd0,   8'd0,   1'b0, 12'h000},
    '{ROW_TICK, 4'hC, 8'd0,   8'd0,   1'b0, 12'h000}
  };

  localparam int PHASES = 8;
  localparam phase_t PHASE_TAB [0:PHASES-1] = '{
    '{8'd70,  8'd35,  200, 1'b1},
    '{8'd1,   8'd1,   80,  1'b1},
    '{8'd255, 8'd255, 260, 1'b1},
    '{8'd0,   8'd0,   60,  1'b1},
    '{8'd8,   8'd5,   100, 1'b1},
    '{8'd3,   8'd12,  100, 1'b1},
    '{8'd20,  8'd6,   100, 1'b1},
    '{8'd6,   8'd4,   200, 1'b0}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  key_press_classifier_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the classifier state and registers.
  kpc_phase_e   phase_q  [NUM_KEYS];
  logic [7:0]   hold_q   [NUM_KEYS];
  logic         win_open [NUM_KEYS];
  logic [7:0]   win_cnt  [NUM_KEYS];
  kpc_cfg_t     cfg_q;

  // Press pattern generator: each key alternates pressed and released runs.
  int           run_left [NUM_KEYS];
  logic [3:0]   key_lvl = 4'hF;

  tick_events_t events_q [$];
  int           mismatches = 0;
  logic         idle_en = 1'b1;
  int           sink_gap = 0;

  function automatic tick_events_t classify_tick(input logic [3:0] lv);
    tick_events_t ev;
    logic up;
    ev = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      up = lv[k];
      case (phase_q[k])
        PH_DEB: phase_q[k] = up ? PH_IDLE : PH_HELD;
        PH_HELD: begin
          if (up) begin
            // A release past the threshold ends the press without an event.
            if (hold_q[k] < cfg_q.long_press_ticks) begin
              if (!win_open[k]) begin
                win_open[k] = 1'b1;
                win_cnt[k]  = 8'd0;
              end else begin
                ev.dbl_mask[k] = 1'b1;
                win_open[k]    = 1'b0;
              end
            end
            phase_q[k] = PH_IDLE;
          end else if (hold_q[k] >= cfg_q.long_press_ticks) begin
            ev.lng_mask[k] = 1'b1;
          end else begin
            hold_q[k] = hold_q[k] + 8'd1;
          end
        end
        default: begin
          if (up) begin
            phase_q[k] = PH_IDLE;
          end else begin
            phase_q[k] = PH_DEB;
            hold_q[k]  = 8'd0;
          end
        end
      endcase
      // The window is counted on the tick that opens it as well.
      if (win_open[k]) begin
        win_cnt[k] = win_cnt[k] + 8'd1;
        if (win_cnt[k] >= cfg_q.double_click_window) begin
          ev.sgl_mask[k] = 1'b1;
          win_open[k]    = 1'b0;
        end
      end
    end
    return ev;
  endfunction

  function automatic logic [3:0] next_levels();
    logic [3:0] lv;
    int hi;
    int bit_sel;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (run_left[k] == 0) begin
        key_lvl[k] = ~key_lvl[k];
        hi = key_lvl[k] ? int'(cfg_q.double_click_window) + 4
                        : int'(cfg_q.long_press_ticks) + 4;
        run_left[k] = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6)
                                                  : $urandom_range(1, hi);
      end
      run_left[k]--;
    end
    lv = key_lvl;
    // Occasional contact bounce on one key.
    if ($urandom_range(0, 11) == 0) begin
      bit_sel = $urandom_range(0, NUM_KEYS - 1);
      lv[bit_sel] = ~lv[bit_sel];
    end
    return lv;
  endfunction

  task automatic send_tick(input logic [3:0] lv);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, lv};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops the source and waits until every tick in flight has produced its result.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (events_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] thr, input logic [7:0] win);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_LONG_PRESS;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_idx_i  <= REG_DBL_WINDOW;
    cfg_data_i <= win;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_q.long_press_ticks    = thr;
    cfg_q.double_click_window = win;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (events_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transfer: tdata=%h", m_axis_tdata);
          mismatches++;
        end else begin
          if (m_axis_tdata[3:0]   != events_q[0].sgl_mask ||
              m_axis_tdata[7:4]   != events_q[0].dbl_mask ||
              m_axis_tdata[11:8]  != events_q[0].lng_mask ||
              m_axis_tdata[15:12] != 4'h0) begin
            if (mismatches < 10)
              $display("result mismatch: expected sgl=%h dbl=%h lng=%h, got tdata=%h",
                       events_q[0].sgl_mask, events_q[0].dbl_mask,
                       events_q[0].lng_mask, m_axis_tdata);
            mismatches++;
          end
          void'(events_q.pop_front());
        end
      end
      if (sink_gap > 0) begin
        sink_gap      <= sink_gap - 1;
        m_axis_tready <= (sink_gap == 1);
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        sink_gap      <= $urandom_range(1, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t     row;
    phase_t       ph;
    tick_events_t predicted;
    logic [3:0]   lv;
    for (int k = 0; k < NUM_KEYS; k++) begin
      phase_q[k]  = PH_IDLE;
      hold_q[k]   = 8'd0;
      win_open[k] = 1'b0;
      win_cnt[k]  = 8'd0;
      run_left[k] = 0;
    end
    cfg_q.long_press_ticks    = LONG_PRESS_RESET;
    cfg_q.double_click_window = DBL_WINDOW_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TAB[r];
      if (row.kind == ROW_CFG) begin
        settle();
        write_config(row.thr, row.win);
      end else begin
        send_tick(row.levels);
        predicted = classify_tick(row.levels);
        events_q.push_back(row.chk ? row.want : predicted);
      end
    end

    // Key state carries over between phases, so a new threshold can hit a key mid-press.
    for (int p = 0; p < PHASES; p++) begin
      ph = PHASE_TAB[p];
      settle();
      write_config(ph.thr, ph.win);
      idle_en = ph.idle;
      for (int n = 0; n < ph.items; n++) begin
        lv = next_levels();
        send_tick(lv);
        events_q.push_back(classify_tick(lv));
      end
    end

    s_axis_tvalid <= 1'b0;
    for (int n = 0; n < 2000 && events_q.size() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (events_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
